@@ rtl/assert_macros.svh @@
// Assertion helpers for the decision tree block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that an expression never holds outside reset
`define CHK_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

@@ rtl/dti_pkg.sv @@
package dti_pkg;

    typedef enum logic [1:0] {
        OP_NODE   = 2'd0,
        OP_CLASS  = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    localparam logic CFG_TASK_MODE   = 1'b0;
    localparam logic CFG_NUM_CLASSES = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_NODE,
        ST_RD_SAMPLE,
        ST_STEP,
        ST_RD_LEAF,
        ST_RD_COUNT,
        ST_DIV,
        ST_EMIT_CLASS,
        ST_EMIT_ONE
    } state_t;

endpackage

@@ rtl/decision_tree_inference_top.sv @@
// Channel      | Direction | Handshake            | Payload
// s_ (items)   | in        | s_valid / s_ready    | opcode, node and class writes, samples
// m_ (results) | out       | m_valid / m_ready    | leaf, class, probability, mean, flags
// cfg          | in        | cfg_valid/cfg_ready  | cfg_index (1 bit), cfg_data (5 bits)
// Table writes and samples that do not end an instance leave the block idle and ready.
// A final sample walks the tree level by level (node table read, sample buffer
// read, compare), bounded by MAX_DEPTH levels; in classification mode each class
// then takes a count read and a restoring divide to a 17-bit quotient, plus the output transfer.
// aresetn is synchronous and active low; it clears control state only; the node
// tables and sample buffer hold undefined contents until written.
// A stall on m_ready holds the current result; s_ready stays low until the
// instance's last result has been transferred.
`include "assert_macros.svh"

module decision_tree_inference_top #(
    parameter int MAX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_node_index,
    input  logic        s_node_is_leaf,
    input  logic [3:0]  s_node_feature,
    input  logic [7:0]  s_left_child,
    input  logic [7:0]  s_right_child,
    input  logic signed [31:0] s_node_value,
    input  logic [19:0] s_node_count,
    input  logic [3:0]  s_class_index,
    input  logic [19:0] s_class_count,
    input  logic signed [31:0] s_sample_value,
    input  logic        s_last_sample,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_leaf_index,
    output logic [3:0]  m_result_class,
    output logic [15:0] m_class_probability,
    output logic signed [31:0] m_regression_value,
    output logic        m_walk_error,
    output logic        m_last_result
);
    import dti_pkg::*;

    localparam int DW = (MAX_DEPTH < 2) ? 1 : $clog2(MAX_DEPTH + 1);

    // node word: leaf, feature, left, right, value, total
    typedef struct packed {
        logic        leaf;
        logic [3:0]  feat;
        logic [7:0]  left;
        logic [7:0]  right;
        logic [31:0] value;
        logic [19:0] total;
    } node_t;

    node_t       node_mem [256];
    logic [19:0] class_mem [4096];
    logic [31:0] samp_mem [16];

    node_t       node_rd_reg;
    logic [19:0] class_rd_reg;
    logic [31:0] samp_rd_reg;

    state_t state_reg, state_next;
    logic        task_mode_reg;
    logic [4:0]  num_classes_reg;
    logic [4:0]  fill_reg, fill_next;
    logic [7:0]  cur_reg, cur_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [3:0]  cls_reg, cls_next;
    logic [3:0]  ncm1_reg, ncm1_next;
    logic [35:0] rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic        out_err_reg, out_err_next;

    logic accept;
    logic [3:0] nc_m1;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;

    // clamp class count: 0 acts as 1, above 16 acts as 16
    always_comb begin
        if (num_classes_reg == 5'd0) begin
            nc_m1 = 4'd0;
        end else if (num_classes_reg > 5'd16) begin
            nc_m1 = 4'd15;
        end else begin
            nc_m1 = 4'(num_classes_reg - 5'd1);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_mode_reg   <= 1'b0;
            num_classes_reg <= 5'd2;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TASK_MODE:   task_mode_reg   <= cfg_data[0];
                CFG_NUM_CLASSES: num_classes_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // memories: write from accepted items, registered reads
    always_ff @(posedge aclk) begin
        if (accept && opcode_t'(s_opcode) == OP_NODE) begin
            node_mem[s_node_index] <= '{s_node_is_leaf, s_node_feature, s_left_child,
                                        s_right_child, s_node_value, s_node_count};
        end
        node_rd_reg <= node_mem[cur_next];
    end

    always_ff @(posedge aclk) begin
        if (accept && opcode_t'(s_opcode) == OP_CLASS) begin
            class_mem[{s_node_index, s_class_index}] <= s_class_count;
        end
        class_rd_reg <= class_mem[{cur_reg, cls_next}];
    end

    always_ff @(posedge aclk) begin
        if (accept && opcode_t'(s_opcode) == OP_SAMPLE && !fill_reg[4]) begin
            samp_mem[fill_reg[3:0]] <= s_sample_value;
        end
        samp_rd_reg <= samp_mem[node_rd_reg.feat];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && opcode_t'(s_opcode) == OP_SAMPLE && s_last_sample) begin
                    state_next = ST_RD_NODE;
                end
            end
            ST_RD_NODE:   state_next = ST_RD_SAMPLE;
            ST_RD_SAMPLE: begin
                if (node_rd_reg.leaf) begin
                    state_next = task_mode_reg ? ST_EMIT_ONE : ST_RD_COUNT;
                end else if (depth_reg == DW'(MAX_DEPTH - 1)) begin
                    state_next = ST_EMIT_ONE;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:      state_next = ST_RD_NODE;
            ST_RD_COUNT:  state_next = ST_DIV;
            ST_DIV: begin
                if (dcnt_reg == 5'd0) state_next = ST_EMIT_CLASS;
            end
            ST_EMIT_CLASS: begin
                if (m_ready) begin
                    state_next = (cls_reg == ncm1_reg) ? ST_IDLE : ST_RD_COUNT;
                end
            end
            ST_EMIT_ONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        logic [36:0] trial;
        fill_next    = fill_reg;
        cur_next     = cur_reg;
        depth_next   = depth_reg;
        cls_next     = cls_reg;
        ncm1_next    = ncm1_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        out_err_next = out_err_reg;
        trial        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && opcode_t'(s_opcode) == OP_SAMPLE) begin
                    if (s_last_sample) begin
                        fill_next  = 5'd0;
                        cur_next   = 8'd0;
                        depth_next = '0;
                        cls_next   = 4'd0;
                        ncm1_next  = nc_m1;
                    end else if (!fill_reg[4]) begin
                        fill_next = fill_reg + 5'd1;
                    end
                end
            end
            ST_RD_SAMPLE: begin
                out_err_next = !node_rd_reg.leaf;
            end
            ST_STEP: begin
                // go right when sample >= threshold
                if ($signed(samp_rd_reg) >= $signed(node_rd_reg.value)) begin
                    cur_next = node_rd_reg.right;
                end else begin
                    cur_next = node_rd_reg.left;
                end
                depth_next = depth_reg + DW'(1);
            end
            ST_RD_COUNT: begin
                rem_next  = {16'd0, class_rd_reg};
                quo_next  = '0;
                dcnt_next = 5'd16;
            end
            ST_DIV: begin
                // restoring division of count<<16 by total, one bit per cycle;
                // seventeen steps against twice the total give the 17-bit quotient
                trial = {rem_reg, 1'b0} - {16'd0, node_rd_reg.total, 1'b0};
                if (!trial[36]) begin
                    rem_next = trial[35:0];
                    quo_next = {quo_reg[15:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[34:0], 1'b0};
                    quo_next = {quo_reg[15:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 5'd1;
            end
            ST_EMIT_CLASS: begin
                if (m_ready && cls_reg != ncm1_reg) cls_next = cls_reg + 4'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= 5'd0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
        cur_reg     <= cur_next;
        depth_reg   <= depth_next;
        cls_reg     <= cls_next;
        ncm1_reg    <= ncm1_next;
        rem_reg     <= {rem_next[35:16] , rem_next[15:0]};
        quo_reg     <= quo_next;
        dcnt_reg    <= dcnt_next;
        out_err_reg <= out_err_next;
    end

    // output drive: the class count and node word hold while a result waits
    always_comb begin
        m_valid             = (state_reg == ST_EMIT_CLASS) || (state_reg == ST_EMIT_ONE);
        m_leaf_index        = 8'd0;
        m_result_class      = 4'd0;
        m_class_probability = 16'd0;
        m_regression_value  = 32'sd0;
        m_walk_error        = 1'b0;
        m_last_result       = 1'b1;
        case (state_reg)
            ST_EMIT_CLASS: begin
                m_leaf_index   = cur_reg;
                m_result_class = cls_reg;
                // a count at or above the total saturates
                if (node_rd_reg.total != 20'd0) begin
                    m_class_probability = (quo_reg[16] || class_rd_reg >= node_rd_reg.total)
                                          ? 16'hFFFF : quo_reg[15:0];
                end
                m_last_result = (cls_reg == ncm1_reg);
            end
            ST_EMIT_ONE: begin
                if (out_err_reg) begin
                    m_walk_error = 1'b1;
                end else begin
                    m_leaf_index       = cur_reg;
                    m_regression_value = node_rd_reg.value;
                end
            end
            default: ;
        endcase
    end

    `CHK_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_ready, "item taken while busy")
    `CHK_IMPL(a_hold_on_stall, aclk, aresetn, m_valid && !m_ready, ##1 m_valid, "result dropped in stall")
    `CHK_NEVER(a_fill_range, aclk, aresetn, fill_reg > 5'd16, "sample fill beyond buffer")
    `CHK_IMPL(a_err_single, aclk, aresetn, m_valid && m_walk_error, m_last_result, "error not last")

endmodule

@@ verif/decision_tree_inference_top_tb.sv @@
`timescale 1ns / 1ps

module decision_tree_inference_top_tb;
    import dti_pkg::*;

    // Item and result layouts, at the block's port widths
    typedef struct packed {
        opcode_t     op;
        logic [7:0]  node;
        logic        is_leaf;
        logic [3:0]  feat;
        logic [7:0]  lchild;
        logic [7:0]  rchild;
        logic [31:0] nval;
        logic [19:0] ncount;
        logic [3:0]  cls;
        logic [19:0] ccount;
        logic [31:0] smp;
        logic        last;
    } tree_item_t;

    typedef struct packed {
        logic [7:0]  leaf;
        logic [3:0]  cls;
        logic [15:0] prob;
        logic [31:0] mean;
        logic        err;
        logic        last;
    } verdict_t;

    typedef struct packed {
        tree_item_t it;
        logic [1:0] n_typed;
        verdict_t   t0;
        verdict_t   t1;
    } dir_row_t;

    localparam int NODES = 256;
    localparam int FEATS = 16;
    localparam int CLASSES = 16;
    localparam int DEPTH = 16;
    localparam int PHASE_ITEMS = 46;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    tree_item_t  drv;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [4:0]  cfg_data;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_leaf_index;
    logic [3:0]  m_result_class;
    logic [15:0] m_class_probability;
    logic signed [31:0] m_regression_value;
    logic        m_walk_error;
    logic        m_last_result;

    decision_tree_inference_top u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (drv.op),
        .s_node_index        (drv.node),
        .s_node_is_leaf      (drv.is_leaf),
        .s_node_feature      (drv.feat),
        .s_left_child        (drv.lchild),
        .s_right_child       (drv.rchild),
        .s_node_value        (drv.nval),
        .s_node_count        (drv.ncount),
        .s_class_index       (drv.cls),
        .s_class_count       (drv.ccount),
        .s_sample_value      (drv.smp),
        .s_last_sample       (drv.last),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_leaf_index        (m_leaf_index),
        .m_result_class      (m_result_class),
        .m_class_probability (m_class_probability),
        .m_regression_value  (m_regression_value),
        .m_walk_error        (m_walk_error),
        .m_last_result       (m_last_result)
    );

    // Clock: 10 ns period
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Shadow copy of the tree table, sample buffer and registers
    bit          regress_mode;
    logic [4:0]  class_setting;
    bit          leaf_flag [NODES];
    logic [3:0]  feat_id [NODES];
    logic [7:0]  left_id [NODES];
    logic [7:0]  right_id [NODES];
    logic [31:0] node_val [NODES];
    logic [19:0] node_total [NODES];
    logic [19:0] class_tally [NODES][CLASSES];
    bit          node_known [NODES];
    bit          tally_known [NODES][CLASSES];
    logic [31:0] smp_buf [FEATS];
    int          smp_fill;

    verdict_t    pending_results[$];
    int          fail_count;
    int          mismatch_count;
    int          items_sent;
    bit          calm;
    bit          stim_done;

    function automatic int active_classes();
        if (class_setting == 0) return 1;
        if (class_setting > CLASSES) return CLASSES;
        return class_setting;
    endfunction

    // Follow the tree from the root; an unfilled sample slot may be given as pending.
    // gap reports the first node on the path that has never been loaded.
    function automatic bit walk_tree(input int pend_slot, input logic [31:0] pend_val,
                                     output int leaf, output int gap);
        int node;
        logic [31:0] s;
        node = 0;
        leaf = 0;
        gap = -1;
        for (int lvl = 0; lvl < DEPTH; lvl++) begin
            if (!node_known[node]) begin
                gap = node;
                return 1'b0;
            end
            if (leaf_flag[node]) begin
                leaf = node;
                return 1'b1;
            end
            s = (feat_id[node] == pend_slot) ? pend_val : smp_buf[feat_id[node]];
            node = ($signed(s) >= $signed(node_val[node])) ? right_id[node] : left_id[node];
        end
        return 1'b0;
    endfunction

    // Update the shadow state with one accepted item and queue what it must produce
    function automatic void predict_tree(input tree_item_t it, input bit queue_it);
        int leaf, gap, nc;
        logic [63:0] p;
        verdict_t v;
        case (it.op)
            OP_NODE: begin
                leaf_flag[it.node]  = it.is_leaf;
                feat_id[it.node]    = it.feat;
                left_id[it.node]    = it.lchild;
                right_id[it.node]   = it.rchild;
                node_val[it.node]   = it.nval;
                node_total[it.node] = it.ncount;
                node_known[it.node] = 1'b1;
            end
            OP_CLASS: begin
                class_tally[it.node][it.cls] = it.ccount;
                tally_known[it.node][it.cls] = 1'b1;
            end
            OP_SAMPLE: begin
                if (smp_fill < FEATS) begin
                    smp_buf[smp_fill] = it.smp;
                    smp_fill++;
                end
                if (it.last) begin
                    smp_fill = 0;
                    if (!walk_tree(-1, '0, leaf, gap)) begin
                        v = '0;
                        v.err = 1'b1;
                        v.last = 1'b1;
                        if (queue_it) pending_results.push_back(v);
                    end else if (regress_mode) begin
                        v = '0;
                        v.leaf = leaf;
                        v.mean = node_val[leaf];
                        v.last = 1'b1;
                        if (queue_it) pending_results.push_back(v);
                    end else begin
                        nc = active_classes();
                        for (int c = 0; c < nc; c++) begin
                            p = 0;
                            if (node_total[leaf] != 0) begin
                                p = {28'd0, class_tally[leaf][c], 16'd0} / node_total[leaf];
                                if (p > 64'hFFFF) p = 64'hFFFF;
                            end
                            v = '0;
                            v.leaf = leaf;
                            v.cls = c;
                            v.prob = p[15:0];
                            v.last = (c == nc - 1);
                            if (queue_it) pending_results.push_back(v);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Present one item, hold it until the transfer, then fold it into the prediction
    task automatic push_item(input tree_item_t it, input bit queue_it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        drv = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_tree(it, queue_it);
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic tree_item_t node_item(input logic [7:0] idx, input bit is_leaf,
                                             input logic [3:0] f, input logic [7:0] l,
                                             input logic [7:0] r, input logic [31:0] v,
                                             input logic [19:0] cnt);
        tree_item_t it;
        it = tree_item_t'(140'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        it.op = OP_NODE;
        it.node = idx;
        it.is_leaf = is_leaf;
        it.feat = f;
        it.lchild = l;
        it.rchild = r;
        it.nval = v;
        it.ncount = cnt;
        return it;
    endfunction

    function automatic tree_item_t class_item(input logic [7:0] idx, input logic [3:0] c,
                                              input logic [19:0] cnt);
        tree_item_t it;
        it = tree_item_t'(140'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        it.op = OP_CLASS;
        it.node = idx;
        it.cls = c;
        it.ccount = cnt;
        return it;
    endfunction

    function automatic tree_item_t sample_item(input logic [31:0] v, input bit last);
        tree_item_t it;
        it = tree_item_t'(140'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        it.op = OP_SAMPLE;
        it.smp = v;
        it.last = last;
        return it;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(0, 8) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [19:0] pick_count();
        case ($urandom_range(0, 4))
            0: return 20'd0;
            1: return 20'hFFFFF;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // Load every node and class tally the coming walk will touch, so that no
    // undefined table entry is ever read
    task automatic fill_walk_path(input logic [31:0] final_smp);
        int leaf, gap, slot;
        bit ok;
        slot = (smp_fill < FEATS) ? smp_fill : -1;
        forever begin
            ok = walk_tree(slot, final_smp, leaf, gap);
            if (gap >= 0) begin
                push_item(node_item(gap, 1'b1, $urandom, $urandom, $urandom,
                                    pick_value(), pick_count()), 1'b1);
            end else begin
                if (ok && !regress_mode)
                    for (int c = 0; c < active_classes(); c++)
                        if (!tally_known[leaf][c])
                            push_item(class_item(leaf, c, pick_count()), 1'b1);
                return;
            end
        end
    endtask

    // One instance: maybe reshape the tree, add some noise, then stream samples
    task automatic run_instance();
        int kind, k, n_smp;
        logic [7:0] ids [8];
        logic [31:0] v;
        kind = $urandom_range(0, 9);
        if (kind <= 4) begin
            k = $urandom_range(2, 8);
            ids[0] = 8'd0;
            for (int i = 1; i < 8; i++) ids[i] = $urandom_range(1, 255);
            for (int i = 0; i < k; i++) begin
                if (2 * i + 1 >= k)
                    push_item(node_item(ids[i], 1'b1, $urandom, $urandom, $urandom,
                                        pick_value(), pick_count()), 1'b1);
                else
                    push_item(node_item(ids[i], 1'b0, $urandom_range(0, 3),
                                        ids[2 * i + 1],
                                        (2 * i + 2 < k) ? ids[2 * i + 2] : ids[2 * i + 1],
                                        pick_value(), pick_count()), 1'b1);
            end
            for (int i = 0; i < 3; i++)
                push_item(class_item(ids[$urandom_range(0, k - 1)], $urandom,
                                     pick_count()), 1'b1);
        end else if (kind == 5) begin
            // chain straight down; a chain deeper than the depth limit makes the walk fail
            k = $urandom_range(14, 17);
            for (int i = 0; i < k; i++)
                push_item(node_item(i, 1'b0, $urandom, i + 1, i + 1, $urandom,
                                    $urandom), 1'b1);
            push_item(node_item(k, 1'b1, $urandom, $urandom, $urandom, pick_value(),
                                pick_count()), 1'b1);
        end else if (kind == 6) begin
            // noise: stray table writes and the unused opcode
            for (int i = 0; i < 3; i++) begin
                tree_item_t it;
                it = tree_item_t'(140'({$urandom, $urandom, $urandom, $urandom, $urandom}));
                if (it.op == OP_SAMPLE) it.op = OP_NONE;
                push_item(it, 1'b1);
            end
        end
        n_smp = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 4);
        for (int i = 0; i < n_smp - 1; i++)
            push_item(sample_item(pick_value(), 1'b0), 1'b1);
        v = pick_value();
        fill_walk_path(v);
        push_item(sample_item(v, 1'b1), 1'b1);
    endtask

    // Wait for every result, then give the block time to settle
    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_TASK_MODE) regress_mode = data[0];
        else class_setting = data;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Result side: random stall bursts, none once the run goes calm
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (calm || $urandom_range(0, 2) != 0) begin
                m_ready = 1'b1;
                repeat ($urandom_range(0, 12)) @(negedge aclk);
            end else begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        verdict_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_leaf_index, m_result_class, m_class_probability, m_regression_value,
                   m_walk_error, m_last_result};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (mismatch_count++ < 10)
                    $display("unexpected result: leaf %0d class %0d prob %h mean %h err %b",
                             got.leaf, got.cls, got.prob, got.mean, got.err);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (mismatch_count++ < 10)
                        $display({"mismatch: leaf %0d/%0d class %0d/%0d prob %h/%h ",
                                  "mean %h/%h err %b/%b last %b/%b (want/got)"},
                                 want.leaf, got.leaf, want.cls, got.cls, want.prob,
                                 got.prob, want.mean, got.mean, want.err, got.err,
                                 want.last, got.last);
                end
            end
        end
    end

    // Hard stop if the block hangs
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        dir_row_t rows[$];
        verdict_t v0, v1;
        int phase_modes [7];
        int phase_classes [7];
        int goal;

        aresetn = 1'b0;
        s_valid = 1'b0;
        drv = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TASK_MODE;
        cfg_data = '0;
        calm = 1'b0;
        stim_done = 1'b0;
        fail_count = 0;
        mismatch_count = 0;
        items_sent = 0;
        regress_mode = 1'b0;
        class_setting = 5'd2;
        smp_fill = 0;
        foreach (node_known[i]) node_known[i] = 1'b0;
        foreach (tally_known[i, j]) tally_known[i][j] = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table: a tiny tree, saturating and zero probabilities, the
        // unused opcode, one sample too many, then a self loop that must fail
        rows.push_back({node_item(0, 1'b0, 0, 1, 2, 32'h0, 20'd0), 2'd0, 62'd0, 62'd0});
        rows.push_back({node_item(1, 1'b1, 0, 0, 0, 32'h8000_0000, 20'd0), 2'd0, 62'd0,
                        62'd0});
        rows.push_back({node_item(2, 1'b1, 15, 255, 255, 32'h7FFF_FFFF, 20'hFFFFF), 2'd0,
                        62'd0, 62'd0});
        rows.push_back({class_item(2, 0, 20'hFFFFF), 2'd0, 62'd0, 62'd0});
        rows.push_back({class_item(2, 1, 20'd0), 2'd0, 62'd0, 62'd0});
        rows.push_back({class_item(2, 15, 20'h80000), 2'd0, 62'd0, 62'd0});
        rows.push_back({{OP_NONE, {138{1'b1}}}, 2'd0, 62'd0, 62'd0});
        rows.push_back({sample_item(32'h7FFF_FFFF, 1'b0), 2'd0, 62'd0, 62'd0});
        for (int i = 1; i < 16; i++)
            rows.push_back({sample_item((i % 3 == 0) ? 32'h0 :
                                        (i % 3 == 1) ? 32'h8000_0000 : 32'hFFFF_FFFF,
                                        1'b0), 2'd0, 62'd0, 62'd0});
        v0 = '0; v0.leaf = 8'd2; v0.prob = 16'hFFFF;
        v1 = '0; v1.leaf = 8'd2; v1.cls = 4'd1; v1.last = 1'b1;
        rows.push_back({sample_item(32'h1234_5678, 1'b1), 2'd2, v0, v1});
        rows.push_back({node_item(0, 1'b0, 1, 3, 3, 32'h0, 20'd5), 2'd0, 62'd0, 62'd0});
        rows.push_back({node_item(3, 1'b0, 2, 3, 3, 32'hFFFF_0000, 20'd5), 2'd0, 62'd0,
                        62'd0});
        v0 = '0; v0.err = 1'b1; v0.last = 1'b1;
        rows.push_back({sample_item(32'h0001_0000, 1'b1), 2'd1, v0, 62'd0});

        foreach (rows[i]) begin
            push_item(rows[i].it, rows[i].n_typed == 0);
            if (rows[i].n_typed > 0) pending_results.push_back(rows[i].t0);
            if (rows[i].n_typed > 1) pending_results.push_back(rows[i].t1);
        end

        // Random phases under different register settings, extremes included
        phase_modes   = '{0, 1, 0, 0, 0, 1, 0};
        phase_classes = '{16, 5, 1, 0, 31, 16, 3};
        for (int ph = 0; ph < 7; ph++) begin
            drain();
            write_reg(CFG_TASK_MODE, phase_modes[ph]);
            write_reg(CFG_NUM_CLASSES, phase_classes[ph]);
            if (ph == 6) calm = 1'b1;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) run_instance();
        end
        stim_done = 1'b1;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
